// ===== rtl/core/sstt_pkg.sv =====
// Shared types, codes and helpers for the sorted software timer table.
// Used by sstt_cell and sorted_software_timer_table; no dependencies.
package sstt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int OWNER_W         = 16;
   localparam int USER_W          = 32;
   localparam int TIME_W          = 32;
   localparam int IVL_W           = 31;

   typedef enum logic [1:0] {
      OP_START_ONE = 2'd0,
      OP_START_PER = 2'd1,
      OP_CANCEL    = 2'd2,
      OP_TICK      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXISTS    = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      CMD_HOLD,    // keep contents
      CMD_INSERT,  // sorted insert of the broadcast timer
      CMD_REMOVE,  // drop the cell whose key matches, close the gap
      CMD_MARK,    // flag the due prefix as pending
      CMD_SHIFT,   // drop the head
      CMD_POP      // drop the head and insert the broadcast timer
   } cmd_op_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [USER_W-1:0]  user;
      logic [TIME_W-1:0]  expiry;
      logic               periodic;
      logic [IVL_W-1:0]   interval;
   } timer_type;

   typedef struct packed {
      cmd_op_type op;
      timer_type  item;
   } cell_cmd_type;

   // What a cell shows its neighbors: contents plus the three running chains.
   typedef struct packed {
      logic      valid;
      logic      pend;
      timer_type data;
      logic      ins;   // insert point at or before this cell
      logic      rem;   // key match at or before this cell
      logic      due;   // every cell up to here is due
   } link_type;

   // True when a lies strictly after b, wrap-aware.
   function automatic logic later(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return (diff != '0) && !diff[TIME_W-1];
   endfunction

endpackage

// ===== rtl/core/sstt_cell.sv =====
// One slot of the sorted timer chain: holds a timer, compares it against the
// broadcast command and moves data to or from its neighbors. Uses sstt_pkg.
module sstt_cell
   import sstt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   input  logic [TIME_W-1:0] now,
   input  link_type          left,
   input  link_type          right,
   output link_type          link
);

   logic              valid_ff, valid_in;
   logic              pend_ff, pend_in;
   timer_type         data_ff, data_in;
   logic              match;
   logic              gap;
   logic              due_here;
   logic              ins_here;
   logic [TIME_W-1:0] elapsed;

   assign match    = valid_ff && (data_ff.owner == cmd.item.owner)
                     && (data_ff.user == cmd.item.user);
   assign gap      = valid_ff && !pend_ff && later(data_ff.expiry, cmd.item.expiry);
   assign elapsed  = now - data_ff.expiry;
   assign due_here = valid_ff && !elapsed[TIME_W-1];
   assign ins_here = left.ins || gap || !valid_ff;

   assign link.valid = valid_ff;
   assign link.pend  = pend_ff;
   assign link.data  = data_ff;
   assign link.ins   = ins_here;
   assign link.rem   = left.rem || match;
   assign link.due   = left.due && due_here;

   always_comb begin
      valid_in = valid_ff;
      pend_in  = pend_ff;
      data_in  = data_ff;
      unique case (cmd.op)
         CMD_HOLD: begin
         end
         CMD_INSERT: begin
            if (left.ins) begin
               valid_in = left.valid;
               pend_in  = left.pend;
               data_in  = left.data;
            end else if (ins_here) begin
               valid_in = 1'b1;
               pend_in  = 1'b0;
               data_in  = cmd.item;
            end
         end
         CMD_REMOVE: begin
            if (link.rem) begin
               valid_in = right.valid;
               pend_in  = right.pend;
               data_in  = right.data;
            end
         end
         CMD_MARK: begin
            pend_in = link.due;
         end
         CMD_SHIFT: begin
            valid_in = right.valid;
            pend_in  = right.pend;
            data_in  = right.data;
         end
         CMD_POP: begin
            // take right short of the insert point, the new timer just before it, hold from it on
            if (!right.ins) begin
               valid_in = right.valid;
               pend_in  = right.pend;
               data_in  = right.data;
            end else if (!ins_here) begin
               valid_in = 1'b1;
               pend_in  = 1'b0;
               data_in  = cmd.item;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      data_ff <= data_in;
   end

endmodule

// ===== rtl/core/sorted_software_timer_table.sv =====
// Sorted software timer table: top level, a chain of sstt_cell slots with a
// small sequencer. Depends on sstt_pkg and sstt_cell.
//
// Usage:
//   The req_ channel carries one request per transaction: start one-shot,
//   start periodic, cancel, or a one-millisecond tick. The rsp_ channel
//   returns one answer per start or cancel (kind 0, with status) and one
//   expiry notice per due timer on a tick (kind 1), with rsp_last marking
//   the final transaction caused by a request. A tick with nothing due
//   returns nothing.
//   Timing: a request is taken while idle and worked on in the next cycle;
//   a start or cancel answer is registered from the execute state, and the
//   next request is taken once the sequencer is idle again. A tick takes the
//   clock step, the mark step and one drain step per expiring timer. One request is in
//   flight at a time; req_ready is high only while the sequencer is idle.
//   The sorted insert, the keyed removal and each head pop act on the whole
//   cell chain at once.
//   Reset clears every slot's valid and pending flag and the clock to zero;
//   the table takes requests as soon as reset is released.
//   When the receiver stalls, the result register holds and the start, cancel and drain
//   steps wait; a new request is still taken, and a tick's clock step and mark do not wait.
module sorted_software_timer_table
   import sstt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [OWNER_W-1:0] req_owner,
   input  logic [USER_W-1:0]  req_user_id,
   input  logic [IVL_W-1:0]   req_timeout_ticks,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [1:0]         rsp_status,
   output logic [OWNER_W-1:0] rsp_expired_owner,
   output logic [USER_W-1:0]  rsp_expired_user_id,
   output logic               rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DRAIN
   } state_type;

   localparam link_type LEFT_EDGE  = '{valid: 1'b0, pend: 1'b0, data: '0,
                                       ins: 1'b0, rem: 1'b0, due: 1'b1};
   localparam link_type RIGHT_EDGE = '{valid: 1'b0, pend: 1'b0, data: '0,
                                       ins: 1'b1, rem: 1'b0, due: 1'b0};

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   op_type             op_ff, op_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [USER_W-1:0]  user_ff, user_in;
   logic [IVL_W-1:0]   tmo_ff, tmo_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;
   logic [USER_W-1:0]  rsp_user_ff, rsp_user_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_cmd_type       cmd;
   link_type           links [TABLE_DEPTH];
   timer_type          head;
   logic [IVL_W-1:0]   ivl_sel;
   logic [TIME_W-1:0]  new_expiry;
   logic               out_free;
   logic               key_found;
   logic               table_full;

   // ---------------------------------------------------------------------
   // Cell chain: slot 0 holds the earliest expiry
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      link_type left_link;
      link_type right_link;
      if (i == 0) begin : g_first
         assign left_link = LEFT_EDGE;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_link = RIGHT_EDGE;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end
      sstt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .now   (time_ff),
         .left  (left_link),
         .right (right_link),
         .link  (links[i])
      );
   end

   assign head       = links[0].data;
   assign key_found  = links[TABLE_DEPTH-1].rem;
   assign table_full = links[TABLE_DEPTH-1].valid;

   // One adder serves both new starts and periodic re-arming.
   assign ivl_sel    = (state_ff == S_DRAIN) ? head.interval : tmo_ff;
   assign new_expiry = time_ff + {1'b0, ivl_sel};

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      time_in       = time_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      user_in       = user_ff;
      tmo_in        = tmo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = CMD_HOLD;
      cmd.item      = '{owner: owner_ff, user: user_ff, expiry: new_expiry,
                        periodic: (op_ff == OP_START_PER), interval: tmo_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // capture the request; a tick advances the clock right away
               op_in    = op_type'(req_operation);
               owner_in = req_owner;
               user_in  = req_user_id;
               tmo_in   = req_timeout_ticks;
               if (op_type'(req_operation) == OP_TICK) begin
                  time_in = time_ff + TIME_W'(1);
               end
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff) inside
               OP_START_ONE, OP_START_PER: begin
                  if (out_free) begin
                     if (key_found) begin
                        rsp_status_in = STATUS_EXISTS;
                     end else if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        cmd.op        = CMD_INSERT;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = 1'b0;
                     rsp_owner_in = owner_ff;
                     rsp_user_in  = user_ff;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               OP_CANCEL: begin
                  if (out_free) begin
                     if (key_found) begin
                        rsp_status_in = STATUS_OK;
                        cmd.op        = CMD_REMOVE;
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = 1'b0;
                     rsp_owner_in = owner_ff;
                     rsp_user_in  = user_ff;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               OP_TICK: begin
                  // freeze the set of due timers before anything re-arms
                  cmd.op   = CMD_MARK;
                  state_in = links[0].due ? S_DRAIN : S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DRAIN: begin
            if (out_free) begin
               // report the head; re-arm it behind the pending prefix if periodic
               cmd.op        = head.periodic ? CMD_POP : CMD_SHIFT;
               cmd.item      = '{owner: head.owner, user: head.user,
                                 expiry: new_expiry, periodic: 1'b1,
                                 interval: head.interval};
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_owner_in  = head.owner;
               rsp_user_in   = head.user;
               rsp_last_in   = !links[1].pend;
               if (!links[1].pend) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      user_ff       <= user_in;
      tmo_ff        <= tmo_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_expired_owner   = rsp_owner_ff;
   assign rsp_expired_user_id = rsp_user_ff;
   assign rsp_last            = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_drain_head_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (links[0].valid && links[0].pend))
      else $error("drain without a pending head timer");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !links[0].pend)
      else $error("pending timers left after a tick finished");

   a_insert_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_INSERT) |-> !links[TABLE_DEPTH-1].valid)
      else $error("insert into a full table");

   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && out_free) |=> (rsp_valid_ff && rsp_kind_ff))
      else $error("drain step did not produce an expiry notice");

endmodule
